>>> sv/v3n_pkg.sv
// v3n_pkg: shared widths and types for the vector normalizer
// no dependencies

package v3n_pkg;

  localparam int unsigned CompWidthDef = 16;
  localparam int unsigned UnitWidth    = 16;
  localparam int unsigned MagWidth     = 16;
  localparam int unsigned UnitFrac     = 14;

  typedef logic [MagWidth-1:0] mag_t;

endpackage

>>> sv/v3n_if.sv
// v3n_if: valid/ready channels for requests and results
// no dependencies

interface v3n_req_if #(parameter int unsigned CompWidth = 16);
  logic                        valid;
  logic                        ready;
  logic signed [CompWidth-1:0] comp_x;
  logic signed [CompWidth-1:0] comp_y;
  logic signed [CompWidth-1:0] comp_z;
  modport source (output valid, comp_x, comp_y, comp_z, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface v3n_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] unit_x;
  logic signed [15:0] unit_y;
  logic signed [15:0] unit_z;
  logic        [15:0] magnitude;
  logic               zero_vector;
  modport source (output valid, unit_x, unit_y, unit_z, magnitude, zero_vector,
                  input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, magnitude, zero_vector,
                  output ready);
endinterface

>>> sv/v3n_sqrt_stage.sv
// v3n_sqrt_stage: one registered step of a restoring square root
// depends on v3n_pkg

module v3n_sqrt_stage
  import v3n_pkg::*;
#(
  parameter int unsigned SqW = 34,
  parameter int unsigned RtW = 17,
  parameter int unsigned StepIdx = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [SqW-1:0] rem_i,
  input  logic [RtW-1:0] root_i,
  output logic [SqW-1:0] rem_o,
  output logic [RtW-1:0] root_o
);

  localparam int unsigned Sh = 2 * (RtW - 1 - StepIdx);

  logic [SqW+1:0] trial;
  logic [SqW+1:0] rem_ext;
  logic [SqW-1:0] rem_d, rem_q;
  logic [RtW-1:0] root_d, root_q;

  // trial = (4*root + 1) << shift
  always_comb begin
    trial   = (({{(SqW+2-RtW){1'b0}}, root_i} << 2) | (SqW+2)'(1)) << Sh;
    rem_ext = {2'b00, rem_i};
    if (rem_ext >= trial) begin
      rem_d  = SqW'(rem_ext - trial);
      root_d = {root_i[RtW-2:0], 1'b1};
    end else begin
      rem_d  = rem_i;
      root_d = {root_i[RtW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

>>> sv/v3n_div_lane.sv
// v3n_div_lane: pipelined restoring divider, one quotient bit per stage
// depends on v3n_pkg

module v3n_div_lane
  import v3n_pkg::*;
#(
  parameter int unsigned NumW = 31,
  parameter int unsigned DenW = 17,
  parameter int unsigned QW   = 15
) (
  input  logic              clk_i,
  input  logic [QW:0]       en_i,
  input  logic [NumW-1:0]   num_i,
  input  logic [DenW-1:0]   den_i,
  input  logic              neg_i,
  output logic [UnitWidth-1:0] unit_o
);

  // quotient fits QW bits (at most 16384), remainder below den
  logic [DenW:0]   rem_q  [QW+1];
  logic [NumW-1:0] num_q  [QW+1];
  logic [DenW-1:0] den_q  [QW+1];
  logic [QW-1:0]   quo_q  [QW+1];
  logic [QW:0]     neg_q;

  // quotient is below 2^QW, so the bits above the last QW start the remainder
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= (DenW+1)'(num_i >> QW);
      num_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= neg_i;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [DenW+1:0] part;
    logic [DenW+1:0] den_ext;
    always_comb begin
      part    = {rem_q[s], num_q[s][QW-1-s]};
      den_ext = {2'b00, den_q[s]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i[s+1]) begin
        if (part >= den_ext) begin
          rem_q[s+1] <= (DenW+1)'(part - den_ext);
          quo_q[s+1] <= {quo_q[s][QW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= (DenW+1)'(part);
          quo_q[s+1] <= {quo_q[s][QW-2:0], 1'b0};
        end
        num_q[s+1] <= num_q[s];
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  // apply the sign to the quotient magnitude
  logic [UnitWidth-1:0] mag;
  assign mag    = UnitWidth'(quo_q[QW]);
  assign unit_o = neg_q[QW] ? UnitWidth'(-mag) : mag;

endmodule

>>> sv/vector3_normalize.sv
// vector3_normalize: length and unit vector of one 3-component vector per request
// throughput one request per cycle while the output is not stalled
// a squaring stage, a pipelined square root and three divider lanes run in lockstep
// the whole pipe advances when the output register is free or being taken
// reset clears the valid bits only; data registers carry no reset

module vector3_normalize
  import v3n_pkg::*;
#(
  parameter int unsigned COMP_WIDTH = CompWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  v3n_req_if.sink   req_i,
  v3n_res_if.source res_o
);

  // widths follow from the component width
  localparam int unsigned AbsW  = COMP_WIDTH;
  localparam int unsigned SqW   = 2 * AbsW + 2;          // sum of three squares
  localparam int unsigned RtW   = SqW / 2;               // root bits
  localparam int unsigned NumW  = AbsW + UnitFrac + 1;   // |c|*2^14 + len/2
  localparam int unsigned QW    = UnitFrac + 1;          // quotient up to 16384
  localparam int unsigned DenW  = RtW;
  localparam int unsigned Depth = 1 + RtW + 1 + (QW + 1) + 1;  // all valid stages

  // pipeline moves when the output slot is empty or being drained
  logic adv;
  logic [Depth-1:0] vld_q;
  assign adv         = !res_o.valid || res_o.ready;
  assign req_i.ready = adv;

  // stage 0: absolute values and squares
  logic [AbsW-1:0] ax_q, ay_q, az_q;
  logic [2:0]      neg_q;
  logic [SqW-1:0]  sq_q;

  function automatic logic [AbsW-1:0] abs_f(input logic [COMP_WIDTH-1:0] v);
    abs_f = v[COMP_WIDTH-1] ? AbsW'(-v) : v;
  endfunction

  logic [AbsW-1:0]   ax_d, ay_d, az_d;
  logic [2*AbsW-1:0] px_d, py_d, pz_d;
  always_comb begin
    ax_d = abs_f(req_i.comp_x);
    ay_d = abs_f(req_i.comp_y);
    az_d = abs_f(req_i.comp_z);
    px_d = ax_d * ax_d;
    py_d = ay_d * ay_d;
    pz_d = az_d * az_d;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q  <= ax_d;
      ay_q  <= ay_d;
      az_q  <= az_d;
      neg_q <= {req_i.comp_z[COMP_WIDTH-1], req_i.comp_y[COMP_WIDTH-1],
                req_i.comp_x[COMP_WIDTH-1]};
      sq_q  <= SqW'(px_d) + SqW'(py_d) + SqW'(pz_d);
    end
  end

  // square root stages carry the components alongside
  logic [SqW-1:0]  rem_w  [RtW+1];
  logic [RtW-1:0]  root_w [RtW+1];
  logic [AbsW-1:0] cx_q [RtW+1], cy_q [RtW+1], cz_q [RtW+1];
  logic [2:0]      ng_q [RtW+1];

  assign rem_w[0]  = sq_q;
  assign root_w[0] = '0;
  always_comb begin
    cx_q[0] = ax_q;
    cy_q[0] = ay_q;
    cz_q[0] = az_q;
    ng_q[0] = neg_q;
  end

  for (genvar i = 0; i < RtW; i++) begin : g_sqrt
    v3n_sqrt_stage #(.SqW(SqW), .RtW(RtW), .StepIdx(i)) u_stage (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (rem_w[i]),
      .root_i (root_w[i]),
      .rem_o  (rem_w[i+1]),
      .root_o (root_w[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cx_q[i+1] <= cx_q[i];
        cy_q[i+1] <= cy_q[i];
        cz_q[i+1] <= cz_q[i];
        ng_q[i+1] <= ng_q[i];
      end
    end
  end

  // rounding: increment root when remainder exceeds it
  logic [DenW-1:0] len_q;
  logic            zero_q;
  logic [AbsW-1:0] rx_q, ry_q, rz_q;
  logic [2:0]      rn_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len_q  <= (rem_w[RtW] > SqW'(root_w[RtW])) ? root_w[RtW] + 1'b1 : root_w[RtW];
      zero_q <= (root_w[RtW] == '0);
      rx_q   <= cx_q[RtW];
      ry_q   <= cy_q[RtW];
      rz_q   <= cz_q[RtW];
      rn_q   <= ng_q[RtW];
    end
  end

  // three divider lanes, one per component
  logic [DenW-1:0] den_safe;
  logic [NumW-1:0] nx, ny, nz;
  assign den_safe = zero_q ? DenW'(1) : len_q;
  assign nx = (NumW'(rx_q) << UnitFrac) + NumW'(len_q >> 1);
  assign ny = (NumW'(ry_q) << UnitFrac) + NumW'(len_q >> 1);
  assign nz = (NumW'(rz_q) << UnitFrac) + NumW'(len_q >> 1);

  logic [QW:0] lane_en;
  assign lane_en = {(QW+1){adv}};

  logic [UnitWidth-1:0] ux, uy, uz;

  v3n_div_lane #(.NumW(NumW), .DenW(DenW), .QW(QW)) u_lane_x (
    .clk_i(clk_i), .en_i(lane_en), .num_i(nx), .den_i(den_safe), .neg_i(rn_q[0]),
    .unit_o(ux));
  v3n_div_lane #(.NumW(NumW), .DenW(DenW), .QW(QW)) u_lane_y (
    .clk_i(clk_i), .en_i(lane_en), .num_i(ny), .den_i(den_safe), .neg_i(rn_q[1]),
    .unit_o(uy));
  v3n_div_lane #(.NumW(NumW), .DenW(DenW), .QW(QW)) u_lane_z (
    .clk_i(clk_i), .en_i(lane_en), .num_i(nz), .den_i(den_safe), .neg_i(rn_q[2]),
    .unit_o(uz));

  // length and zero flag travel beside the lanes
  logic [DenW-1:0] lenp_q [QW+1];
  logic [QW:0]     zp_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lenp_q[0] <= len_q;
      zp_q[0]   <= zero_q;
    end
  end
  for (genvar k = 0; k < QW; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv) begin
        lenp_q[k+1] <= lenp_q[k];
        zp_q[k+1]   <= zp_q[k];
      end
    end
  end

  // merge stage: saturate length, force zeros on a zero vector
  logic [MagWidth-1:0] mag_d;
  assign mag_d = (lenp_q[QW] > DenW'({MagWidth{1'b1}})) ? {MagWidth{1'b1}}
                 : MagWidth'(lenp_q[QW]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_o.unit_x      <= zp_q[QW] ? '0 : ux;
      res_o.unit_y      <= zp_q[QW] ? '0 : uy;
      res_o.unit_z      <= zp_q[QW] ? '0 : uz;
      res_o.magnitude   <= zp_q[QW] ? '0 : mag_d;
      res_o.zero_vector <= zp_q[QW];
    end
  end

  // valid bits shift with the pipe; the last one is the output slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], req_i.valid};
    end
  end
  assign res_o.valid = vld_q[Depth-1];

  // a stalled result stays valid and keeps its magnitude
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> $stable(res_o.magnitude) && res_o.valid)
    else $error("result changed while stalled");

  // zero flag implies zero magnitude and zero unit_x
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.zero_vector |-> res_o.magnitude == '0 && res_o.unit_x == '0)
    else $error("zero vector with nonzero payload");

  // ready follows the output slot
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_o.valid |-> req_i.ready)
    else $error("input stalled with empty output");

endmodule
